/* rtl/ccfd_pkg.sv */
// ----------------------------------------------------------------------------
// ccfd_pkg
// Shared types, codes and the CRC-16/ARC byte update for the frame deframer.
// ----------------------------------------------------------------------------
package ccfd_pkg;

  // Longest group of 7-bit digits allowed for a decoded field
  localparam logic [2:0] MaxGroups = 3'd4;

  localparam logic [7:0]  SofByte  = 8'h7F;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam int unsigned FieldW   = 28;

  typedef enum logic [1:0] {
    KIND_FLAG = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_CRC    = 3'd2,
    ST_SOF    = 3'd3,
    ST_FIELD  = 3'd4,
    ST_LENGTH = 3'd5
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         out_byte;
    logic [FieldW-1:0]  frame_type;
    logic [FieldW-1:0]  flag_type;
    status_e            status;
    logic               run_end;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/ccfd_if.sv */
// ----------------------------------------------------------------------------
// ccfd_if
// Valid/ready channels carrying raw frame bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface ccfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

interface ccfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [27:0] frame_type;
  logic [27:0] flag_type;
  logic [2:0]  status;
  logic        run_end;

  modport source (output valid, output kind, output out_byte, output frame_type,
                  output flag_type, output status, output run_end, input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_type,
                  input flag_type, input status, input run_end, output ready);
endinterface

/* rtl/crc_checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Streaming deframer for CRC-16/ARC checked frames, one raw byte per beat.
// ----------------------------------------------------------------------------
// One input beat is taken every clock while the result queue has room for two
// entries. Each beat is parsed in the cycle it is accepted: the byte leaving the
// two-byte delay updates the CRC and the field parser, and any flag data or
// payload byte plus, on the frame's last beat, the frame end status are pushed
// into a four-entry result queue. While the sink keeps up the queue drains one
// result per cycle, so a stream sustains one beat per cycle; the frame end beat
// adds one extra result, which the queue absorbs without stalling.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer
  import ccfd_pkg::*;
#(
  parameter logic [2:0] GroupLimit = MaxGroups
) (
  input  logic clk_i,
  input  logic rst_ni,
  ccfd_in_if.sink    in_i,
  ccfd_out_if.source out_o
);

  typedef enum logic [2:0] {
    PhSof   = 3'd0,
    PhType  = 3'd1,
    PhFtype = 3'd2,
    PhFlen  = 3'd3,
    PhFdata = 3'd4,
    PhPlen  = 3'd5,
    PhPay   = 3'd6
  } phase_e;

  localparam logic [FieldW-1:0] FieldZero = '0;

  // Parser state
  logic [7:0]        dly0_q, dly0_d, dly1_q, dly1_d;
  logic [1:0]        fill_q, fill_d;
  logic [15:0]       crc_q, crc_d;
  phase_e            phase_q, phase_d;
  logic [FieldW-1:0] gval_q, gval_d;
  logic [2:0]        gcnt_q, gcnt_d;
  logic [FieldW-1:0] left_q, left_d;
  logic [FieldW-1:0] type_q, type_d;
  logic [FieldW-1:0] ftype_q, ftype_d;
  logic [2:0]        short_q, short_d;
  logic [2:0]        perr_q, perr_d;

  // Result queue
  result_t     fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;

  logic        accept, pop;
  logic        emit_data;
  kind_e       data_kind;
  status_e     end_status;
  result_t     data_res, end_res, res0, res1;
  logic [1:0]  n_push;

  logic [7:0]  rel;
  logic [55:0] part;
  logic [5:0]  shamt;
  logic [2:0]  gcnt_inc;
  logic [FieldW-1:0] gval_new;
  logic [15:0] got;

  assign in_i.ready = (count_q <= 3'd2);
  assign accept     = in_i.valid & in_i.ready;
  assign pop        = out_o.valid & out_o.ready;

  assign rel      = dly0_q;
  assign shamt    = 6'(gcnt_q) * 6'd7;
  assign part     = 56'(rel[6:0]) << shamt;
  assign gval_new = gval_q | part[FieldW-1:0];
  assign gcnt_inc = gcnt_q + 3'd1;

  // Parse one beat: release the delayed byte, update fields, close frame
  always_comb begin
    dly0_d    = dly1_q;
    dly1_d    = in_i.in_byte;
    fill_d    = (fill_q < 2'd2) ? fill_q + 2'd1 : fill_q;
    crc_d     = crc_q;
    phase_d   = phase_q;
    gval_d    = gval_q;
    gcnt_d    = gcnt_q;
    left_d    = left_q;
    type_d    = type_q;
    ftype_d   = ftype_q;
    short_d   = (short_q < 3'd7) ? short_q + 3'd1 : short_q;
    perr_d    = perr_q;
    emit_data = 1'b0;
    data_kind = KIND_FLAG;

    if (fill_q == 2'd2) begin
      crc_d = crc_byte(crc_q, rel);
      if (perr_q == 3'd0) begin
        case (phase_q)
          PhSof: begin
            if (rel != SofByte) begin
              perr_d = ST_SOF;
            end else begin
              phase_d = PhType;
              gval_d  = FieldZero;
              gcnt_d  = 3'd0;
            end
          end
          PhType, PhFtype, PhFlen, PhPlen: begin
            gval_d = gval_new;
            gcnt_d = gcnt_inc;
            if (rel[7]) begin
              gval_d = FieldZero;
              gcnt_d = 3'd0;
              case (phase_q)
                PhType: begin
                  type_d  = gval_new;
                  phase_d = PhFtype;
                end
                PhFtype: begin
                  ftype_d = gval_new;
                  phase_d = PhFlen;
                end
                PhFlen: begin
                  left_d  = gval_new;
                  phase_d = (gval_new != FieldZero) ? PhFdata : PhPlen;
                end
                default: begin
                  left_d  = gval_new;
                  phase_d = PhPay;
                end
              endcase
            end else if (gcnt_inc >= GroupLimit) begin
              perr_d = ST_FIELD;
            end
          end
          PhFdata: begin
            left_d    = left_q - FieldW'(1);
            if (left_d == FieldZero) begin
              phase_d = PhPlen;
            end
            emit_data = 1'b1;
            data_kind = KIND_FLAG;
          end
          PhPay: begin
            if (left_q == FieldZero) begin
              perr_d = ST_LENGTH;
            end else begin
              left_d    = left_q - FieldW'(1);
              emit_data = 1'b1;
              data_kind = KIND_PAY;
            end
          end
          default: begin
            perr_d = ST_FIELD;
          end
        endcase
      end
    end

    // Frame end status in priority order
    got = {dly1_d, dly0_d};
    if (short_d < 3'd7) begin
      end_status = ST_SHORT;
    end else if (got != crc_d) begin
      end_status = ST_CRC;
    end else if (perr_d != 3'd0) begin
      end_status = status_e'(perr_d);
    end else if (phase_d == PhSof) begin
      end_status = ST_SOF;
    end else if (phase_d == PhPay) begin
      end_status = (left_d != FieldZero) ? ST_LENGTH : ST_OK;
    end else begin
      end_status = ST_FIELD;
    end

    data_res = '{kind: data_kind, out_byte: rel, frame_type: FieldZero,
                 flag_type: FieldZero, status: ST_OK, run_end: ~in_i.frame_last};
    end_res  = '{kind: KIND_END, out_byte: 8'h00, frame_type: type_d,
                 flag_type: ftype_d, status: end_status, run_end: 1'b1};

    // Order results into the queue slots
    res0   = emit_data ? data_res : end_res;
    res1   = end_res;
    n_push = 2'(emit_data) + 2'(in_i.frame_last);

    // Drop all per-frame state after the end beat
    if (in_i.frame_last) begin
      dly0_d  = 8'h00;
      dly1_d  = 8'h00;
      fill_d  = 2'd0;
      crc_d   = 16'h0000;
      phase_d = PhSof;
      gval_d  = FieldZero;
      gcnt_d  = 3'd0;
      left_d  = FieldZero;
      type_d  = FieldZero;
      ftype_d = FieldZero;
      short_d = 3'd0;
      perr_d  = 3'd0;
    end
  end

  // Hold parser state, advance on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly0_q  <= 8'h00;
      dly1_q  <= 8'h00;
      fill_q  <= 2'd0;
      crc_q   <= 16'h0000;
      phase_q <= PhSof;
      gval_q  <= FieldZero;
      gcnt_q  <= 3'd0;
      left_q  <= FieldZero;
      type_q  <= FieldZero;
      ftype_q <= FieldZero;
      short_q <= 3'd0;
      perr_q  <= 3'd0;
    end else if (accept) begin
      dly0_q  <= dly0_d;
      dly1_q  <= dly1_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      phase_q <= phase_d;
      gval_q  <= gval_d;
      gcnt_q  <= gcnt_d;
      left_q  <= left_d;
      type_q  <= type_d;
      ftype_q <= ftype_d;
      short_q <= short_d;
      perr_q  <= perr_d;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + n_push;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (accept ? 3'(n_push) : 3'd0) - 3'(pop);
    end
  end

  // Write up to two results per beat
  always_ff @(posedge clk_i) begin
    if (accept && (n_push != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (accept && (n_push == 2'd2)) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // Present the queue head
  assign out_o.valid      = (count_q != 3'd0);
  assign out_o.kind       = fifo_q[rd_ptr_q].kind;
  assign out_o.out_byte   = fifo_q[rd_ptr_q].out_byte;
  assign out_o.frame_type = fifo_q[rd_ptr_q].frame_type;
  assign out_o.flag_type  = fifo_q[rd_ptr_q].flag_type;
  assign out_o.status     = fifo_q[rd_ptr_q].status;
  assign out_o.run_end    = fifo_q[rd_ptr_q].run_end;

endmodule
